// ===== rtl/gths_pkg.sv =====
// Shared types and constants for the grid terrain height sampler.
// Depends on nothing; the divider, sampler, checker and testbench import it.
package gths_pkg;

    localparam int GRID_COUNT_W = 15;
    localparam int INTERVAL_W   = 11;
    localparam int INDEX_W      = 14;
    localparam int HEIGHT_W     = 32;
    localparam int POS_W        = 32;
    localparam int FRAC_W       = 8;
    localparam int CELL_W       = POS_W - FRAC_W;
    localparam int CFG_INDEX_W  = 2;

    localparam int MAX_VERTICES_DEF   = 16384;
    localparam int DIV_BITS_PER_STAGE = 4;

    localparam logic [GRID_COUNT_W-1:0] GRID_COUNT_RST = 15'd129;
    localparam logic [INTERVAL_W-1:0]   INTERVAL_RST   = 11'd1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic {
        STATUS_OK           = 1'b0,
        STATUS_OUT_OF_RANGE = 1'b1
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_COUNT_X  = 2'd0,
        CFG_GRID_COUNT_Z  = 2'd1,
        CFG_GRID_INTERVAL = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [INDEX_W-1:0]    vertex_index;
        logic [HEIGHT_W-1:0]   vertex_height;
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_z;
    } in_item_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        status_t             status;
    } out_item_t;

    // Fields that ride along the cell divider.
    typedef struct packed {
        opcode_t             opcode;
        logic [INDEX_W-1:0]  vertex_index;
        logic [HEIGHT_W-1:0] vertex_height;
        logic [FRAC_W-1:0]   frac_x;
        logic [FRAC_W-1:0]   frac_z;
    } crd_side_t;

    // Fields that ride along the final divider.
    typedef struct packed {
        logic query;
        logic oor;
        logic neg;
    } res_side_t;

endpackage

// ===== rtl/gths_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gths_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gths_div.sv =====
// Pipelined restoring divider: BPS quotient bits per stage, LANES dividends
// share one divisor. Depends on gths_pkg for the default bits per stage.
module gths_div
    import gths_pkg::*;
#(
    parameter int DW    = 24,
    parameter int VW    = 11,
    parameter int BPS   = DIV_BITS_PER_STAGE,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][DW-1:0]   in_dividend,
    input  logic [VW-1:0]              in_divisor,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][DW-1:0]   out_quot,
    output logic [LANES-1:0][VW-1:0]   out_rem,
    output logic [SW-1:0]              out_side
);

    localparam int NS = (DW + BPS - 1) / BPS;
    localparam int PW = NS * BPS;

    logic [NS-1:0]            vld_reg;
    logic [LANES-1:0][PW-1:0] quo_reg  [NS];
    logic [LANES-1:0][VW-1:0] rem_reg  [NS];
    logic [SW-1:0]            side_reg [NS];

    for (genvar st = 0; st < NS; st++) begin : g_stage
        logic                     vld_cur;
        logic [LANES-1:0][PW-1:0] quo_cur;
        logic [LANES-1:0][PW-1:0] quo_next;
        logic [LANES-1:0][VW-1:0] rem_cur;
        logic [LANES-1:0][VW-1:0] rem_next;
        logic [SW-1:0]            side_cur;

        if (st == 0) begin : g_first
            assign vld_cur  = in_valid;
            assign side_cur = in_side;
            assign rem_cur  = '0;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign quo_cur[l] = PW'(in_dividend[l]);
            end
        end else begin : g_later
            assign vld_cur  = vld_reg[st-1];
            assign side_cur = side_reg[st-1];
            assign rem_cur  = rem_reg[st-1];
            assign quo_cur  = quo_reg[st-1];
        end

        always_comb begin
            logic [VW:0]    t;
            logic [VW-1:0]  r;
            logic [PW-1:0]  q;
            t        = '0;
            r        = '0;
            q        = '0;
            quo_next = quo_cur;
            rem_next = rem_cur;
            for (int l = 0; l < LANES; l++) begin
                r = rem_cur[l];
                q = quo_cur[l];
                for (int b = 0; b < BPS; b++) begin
                    // shift the next dividend bit into the partial remainder
                    t = {r, q[PW-1]};
                    q = {q[PW-2:0], 1'b0};
                    if (t >= {1'b0, in_divisor}) begin
                        t    = t - {1'b0, in_divisor};
                        q[0] = 1'b1;
                    end
                    r = t[VW-1:0];
                end
                quo_next[l] = q;
                rem_next[l] = r;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[st] <= 1'b0;
            end else if (en) begin
                vld_reg[st] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[st]  <= quo_next;
                rem_reg[st]  <= rem_next;
                side_reg[st] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_rem   = rem_reg[NS-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_quot[l] = quo_reg[NS-1][l][DW-1:0];
    end

endmodule

// ===== rtl/grid_terrain_height_sampler.sv =====
// One beat accepted per cycle while no stalled result holds the whole pipeline.
// The two dividers (cell lookup, 6 stages; final scale, 11 stages) set the depth.
// A write beat produces no result; it lands in the height store from stage b.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// configuration to 129 x 129 vertices at interval 1; the store is not cleared.
module grid_terrain_height_sampler
    import gths_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  in_item_t                s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output out_item_t               m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [GRID_COUNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [31:0] MAX_V32 = 32'(MAX_VERTICES);
    localparam int WW = INTERVAL_W + FRAC_W;      // cell size and weights
    localparam int PRW = HEIGHT_W + WW + 1;       // product width
    localparam int SUMW = PRW + 2;
    localparam int MAGW = HEIGHT_W + WW - FRAC_W; // |N| >> 8

    // configuration
    logic [GRID_COUNT_W-1:0] gcx_reg;
    logic [GRID_COUNT_W-1:0] gcz_reg;
    logic [INTERVAL_W-1:0]   intv_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gcx_reg  <= GRID_COUNT_RST;
            gcz_reg  <= GRID_COUNT_RST;
            intv_reg <= INTERVAL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GRID_COUNT_X:  gcx_reg  <= cfg_data;
                CFG_GRID_COUNT_Z:  gcz_reg  <= cfg_data;
                CFG_GRID_INTERVAL: intv_reg <= cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together; hold everything while the result waits
    logic en;
    logic out_vld_reg;
    out_item_t out_data_reg;

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;
    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    // stage p0: input register
    logic     p0_vld_reg;
    in_item_t p0_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
        end else if (en) begin
            p0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_item_reg <= s_data;
        end
    end

    // cell divider: lane 0 is x, lane 1 is z
    logic [1:0][CELL_W-1:0]     crd_dividend;
    logic [1:0][CELL_W-1:0]     crd_quot;
    logic [1:0][INTERVAL_W-1:0] crd_rem;
    crd_side_t                  crd_side_in;
    crd_side_t                  crd_side_out;
    logic                       crd_vld;

    assign crd_dividend[0] = p0_item_reg.pos_x[POS_W-1:FRAC_W];
    assign crd_dividend[1] = p0_item_reg.pos_z[POS_W-1:FRAC_W];
    assign crd_side_in.opcode        = p0_item_reg.opcode;
    assign crd_side_in.vertex_index  = p0_item_reg.vertex_index;
    assign crd_side_in.vertex_height = p0_item_reg.vertex_height;
    assign crd_side_in.frac_x        = p0_item_reg.pos_x[FRAC_W-1:0];
    assign crd_side_in.frac_z        = p0_item_reg.pos_z[FRAC_W-1:0];

    gths_div #(
        .DW    (CELL_W),
        .VW    (INTERVAL_W),
        .BPS   (DIV_BITS_PER_STAGE),
        .LANES (2),
        .SW    ($bits(crd_side_t))
    ) u_crd_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (p0_vld_reg),
        .in_dividend (crd_dividend),
        .in_divisor  (intv_reg),
        .in_side     (crd_side_in),
        .out_valid   (crd_vld),
        .out_quot    (crd_quot),
        .out_rem     (crd_rem),
        .out_side    (crd_side_out)
    );

    // stage a: bounds check, row times row length
    logic                      a_vld_reg;
    logic                      a_query_reg;
    logic                      a_wr_reg;
    logic [INDEX_W-1:0]        a_idx_reg;
    logic [HEIGHT_W-1:0]       a_vh_reg;
    logic                      a_oor_reg;
    logic [2*GRID_COUNT_W-1:0] a_prod_reg;
    logic [GRID_COUNT_W-1:0]   a_col_reg;
    logic [WW-1:0]             a_dx_reg;
    logic [WW-1:0]             a_dz_reg;
    logic                      a_oor_next;

    always_comb begin
        a_oor_next = (intv_reg == '0) || (gcx_reg < GRID_COUNT_W'(2))
                  || (gcz_reg < GRID_COUNT_W'(2))
                  || (({1'b0, crd_quot[0]} + (CELL_W+1)'(1)) >= (CELL_W+1)'(gcx_reg))
                  || (({1'b0, crd_quot[1]} + (CELL_W+1)'(1)) >= (CELL_W+1)'(gcz_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= crd_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_query_reg <= (crd_side_out.opcode == OP_QUERY);
            a_wr_reg    <= (crd_side_out.opcode == OP_WRITE)
                        && (32'(crd_side_out.vertex_index) < MAX_V32);
            a_idx_reg   <= crd_side_out.vertex_index;
            a_vh_reg    <= crd_side_out.vertex_height;
            a_oor_reg   <= a_oor_next;
            a_prod_reg  <= (2*GRID_COUNT_W)'(crd_quot[1][GRID_COUNT_W-1:0])
                         * (2*GRID_COUNT_W)'(gcx_reg);
            a_col_reg   <= crd_quot[0][GRID_COUNT_W-1:0];
            a_dx_reg    <= {crd_rem[0], crd_side_out.frac_x};
            a_dz_reg    <= {crd_rem[1], crd_side_out.frac_z};
        end
    end

    // stage b: vertex addresses and store bound
    logic            b_vld_reg;
    logic            b_query_reg;
    logic            b_wr_reg;
    logic [AW-1:0]   b_widx_reg;
    logic [31:0]     b_vh_reg;
    logic            b_oor_reg;
    logic [AW-1:0]   b_addr_reg [4];
    logic [WW-1:0]   b_dx_reg;
    logic [WW-1:0]   b_dz_reg;
    logic [31:0]     base;
    logic [31:0]     top;

    assign base = 32'(a_prod_reg) + 32'(a_col_reg);
    assign top  = base + 32'(gcx_reg) + 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_query_reg   <= a_query_reg;
            b_wr_reg      <= a_wr_reg;
            b_widx_reg    <= AW'(a_idx_reg);
            b_vh_reg      <= a_vh_reg;
            b_oor_reg     <= a_oor_reg || (top >= MAX_V32);
            b_addr_reg[0] <= base[AW-1:0];
            b_addr_reg[1] <= AW'(base + 32'd1);
            b_addr_reg[2] <= AW'(base + 32'(gcx_reg));
            b_addr_reg[3] <= top[AW-1:0];
            b_dx_reg      <= a_dx_reg;
            b_dz_reg      <= a_dz_reg;
        end
    end

    // stage c: store read (one copy per corner), triangle pick, weights
    logic [HEIGHT_W-1:0] h_rd [4];
    logic                ram_we;

    assign ram_we = en && b_vld_reg && b_wr_reg;

    for (genvar k = 0; k < 4; k++) begin : g_store
        gths_ram #(
            .WIDTH (HEIGHT_W),
            .DEPTH (MAX_VERTICES)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (b_widx_reg),
            .wdata (b_vh_reg),
            .re    (en),
            .raddr (b_addr_reg[k]),
            .rdata (h_rd[k])
        );
    end

    logic          c_vld_reg;
    logic          c_query_reg;
    logic          c_oor_reg;
    logic          c_upper_reg;
    logic [WW-1:0] c_wa_reg;
    logic [WW-1:0] c_w10_reg;
    logic [WW-1:0] c_w01_reg;
    logic [WW:0]   cell_s;
    logic [WW:0]   dxz;
    logic          upper;

    assign cell_s = {1'b0, intv_reg, {FRAC_W{1'b0}}};
    assign dxz    = {1'b0, b_dx_reg} + {1'b0, b_dz_reg};
    assign upper  = dxz > cell_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    // weights are nonnegative and sum to the cell size
    always_ff @(posedge aclk) begin
        if (en) begin
            c_query_reg <= b_query_reg;
            c_oor_reg   <= b_oor_reg;
            c_upper_reg <= upper;
            if (upper) begin
                c_wa_reg  <= WW'(dxz - cell_s);
                c_w10_reg <= WW'(cell_s - {1'b0, b_dz_reg});
                c_w01_reg <= WW'(cell_s - {1'b0, b_dx_reg});
            end else begin
                c_wa_reg  <= WW'(cell_s - dxz);
                c_w10_reg <= b_dx_reg;
                c_w01_reg <= b_dz_reg;
            end
        end
    end

    // stage d: three products
    logic                  d_vld_reg;
    logic                  d_query_reg;
    logic                  d_oor_reg;
    logic signed [PRW-1:0] d_pa_reg;
    logic signed [PRW-1:0] d_p10_reg;
    logic signed [PRW-1:0] d_p01_reg;
    logic [HEIGHT_W-1:0]   h_a;

    assign h_a = c_upper_reg ? h_rd[3] : h_rd[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_query_reg <= c_query_reg;
            d_oor_reg   <= c_oor_reg;
            d_pa_reg    <= PRW'($signed(h_a)) * PRW'($signed({1'b0, c_wa_reg}));
            d_p10_reg   <= PRW'($signed(h_rd[1])) * PRW'($signed({1'b0, c_w10_reg}));
            d_p01_reg   <= PRW'($signed(h_rd[2])) * PRW'($signed({1'b0, c_w01_reg}));
        end
    end

    // stage e: sum, magnitude, drop the fraction bits of the cell size
    logic                   e_vld_reg;
    res_side_t              e_side_reg;
    logic [MAGW-1:0]        e_mag_reg;
    logic signed [SUMW-1:0] num;
    logic [SUMW-1:0]        num_abs;

    assign num     = SUMW'(d_pa_reg) + SUMW'(d_p10_reg) + SUMW'(d_p01_reg);
    assign num_abs = num[SUMW-1] ? SUMW'(-num) : SUMW'(num);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_side_reg.query <= d_query_reg;
            e_side_reg.oor   <= d_oor_reg;
            e_side_reg.neg   <= num[SUMW-1];
            e_mag_reg        <= num_abs[MAGW+FRAC_W-1:FRAC_W];
        end
    end

    // final divider: magnitude over the interval
    logic                  res_vld;
    logic [0:0][MAGW-1:0]  res_dividend;
    logic [0:0][MAGW-1:0]  res_quot;
    logic [0:0][INTERVAL_W-1:0] res_rem;
    res_side_t             res_side;
    logic [HEIGHT_W-1:0]   q_lo;

    assign res_dividend[0] = e_mag_reg;

    gths_div #(
        .DW    (MAGW),
        .VW    (INTERVAL_W),
        .BPS   (DIV_BITS_PER_STAGE),
        .LANES (1),
        .SW    ($bits(res_side_t))
    ) u_res_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (e_vld_reg),
        .in_dividend (res_dividend),
        .in_divisor  (intv_reg),
        .in_side     (e_side_reg),
        .out_valid   (res_vld),
        .out_quot    (res_quot),
        .out_rem     (res_rem),
        .out_side    (res_side)
    );

    // the remainder is not needed; the quotient is already truncated toward zero
    assign q_lo = res_quot[0][HEIGHT_W-1:0] | HEIGHT_W'(res_rem[0] & '0);

    // output register: only queries produce a beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= res_vld && res_side.query;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (res_side.oor) begin
                out_data_reg.height <= '0;
                out_data_reg.status <= STATUS_OUT_OF_RANGE;
            end else begin
                out_data_reg.height <= res_side.neg ? HEIGHT_W'(-q_lo) : q_lo;
                out_data_reg.status <= STATUS_OK;
            end
        end
    end

endmodule

// ===== rtl/gths_chk.sv =====
// Port-level checker for the grid terrain height sampler, bound to the top.
// Depends on gths_pkg.
module gths_chk
    import gths_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input in_item_t                s_data,
    input logic                    m_valid,
    input logic                    m_ready,
    input out_item_t               m_data,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [CFG_INDEX_W-1:0]  cfg_index,
    input logic [GRID_COUNT_W-1:0] cfg_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // out of range answers carry a zero height
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_OUT_OF_RANGE) |-> (m_data.height == '0))
        else $error("out of range result with nonzero height");

    // with no result pending the input side must take beats
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

endmodule

bind grid_terrain_height_sampler gths_chk u_gths_chk (.*);

// ===== tb/tb.sv =====
// Testbench for grid_terrain_height_sampler: random and directed vertex writes and queries,
// checked against a built-in plane interpolator. Depends on gths_pkg and the sampler RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gths_pkg::*;

    localparam int STORE_DEPTH = 16384;
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 3000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [GRID_COUNT_W-1:0] cfg_data;

    grid_terrain_height_sampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the block's state and registers.
    logic signed [HEIGHT_W-1:0] vtx_height [STORE_DEPTH];
    bit vtx_written [STORE_DEPTH];
    int unsigned count_x;
    int unsigned count_z;
    int unsigned interval;

    out_item_t heights_due[$];
    int errors;
    int sent_beats;
    int src_idle_pct;
    int snk_stall_pct;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each result beat with the oldest expected height.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (heights_due.size() == 0) begin
                $display("%0t unexpected result height=%h status=%0d",
                         $time, m_data.height, m_data.status);
                errors++;
            end else begin
                want = heights_due.pop_front();
                if (m_data.height !== want.height || m_data.status !== want.status) begin
                    $display("%0t mismatch expected height=%h status=%0d actual height=%h status=%0d",
                             $time, want.height, want.status, m_data.height, m_data.status);
                    errors++;
                end
            end
        end
    end

    // Locate the cell of a position; returns 0 when the query is out of range.
    function automatic bit locate_cell(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz,
                                       output longint base, output longint top);
        longint s;
        longint col;
        longint row;
        base = 0;
        top = 0;
        if (interval == 0 || count_x < 2 || count_z < 2) return 0;
        s = longint'(interval) << FRAC_W;
        col = longint'(px) / s;
        row = longint'(pz) / s;
        if (col + 1 >= count_x || row + 1 >= count_z) return 0;
        base = row * count_x + col;
        top = base + count_x + 1;
        return top < STORE_DEPTH;
    endfunction

    function automatic out_item_t interpolate_height(input logic [POS_W-1:0] px,
                                                     input logic [POS_W-1:0] pz);
        out_item_t r;
        longint base, top, s, dx, dz, h00, h10, h01, h11, num, h;
        r.height = '0;
        r.status = STATUS_OUT_OF_RANGE;
        if (!locate_cell(px, pz, base, top)) return r;
        s = longint'(interval) << FRAC_W;
        dx = longint'(px) % s;
        dz = longint'(pz) % s;
        h00 = vtx_height[base];
        h10 = vtx_height[base + 1];
        h01 = vtx_height[base + count_x];
        h11 = vtx_height[top];
        if (dx + dz > s)
            num = h11 * s + (h01 - h11) * (s - dx) + (h10 - h11) * (s - dz);
        else
            num = h00 * s + (h10 - h00) * dx + (h01 - h00) * dz;
        h = num / s;
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        r.height = h[HEIGHT_W-1:0];
        r.status = STATUS_OK;
        return r;
    endfunction

    task automatic send_beat(input in_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sent_beats++;
        // Accepted: update the shadow store or queue the expected height.
        if (it.opcode == OP_WRITE) begin
            vtx_height[it.vertex_index] = it.vertex_height;
            vtx_written[it.vertex_index] = 1'b1;
        end else begin
            heights_due.push_back(interpolate_height(it.pos_x, it.pos_z));
        end
    endtask

    function automatic logic [HEIGHT_W-1:0] rand_height();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(4000)) - 2000);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_vertex(input int unsigned idx, input logic [HEIGHT_W-1:0] h);
        in_item_t it;
        it.opcode = OP_WRITE;
        it.vertex_index = idx[INDEX_W-1:0];
        it.vertex_height = h;
        it.pos_x = $urandom;
        it.pos_z = $urandom;
        send_beat(it);
    endtask

    // Load any vertex of the cell still unwritten, then query.
    task automatic query_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        in_item_t it;
        longint base, top;
        longint corner [4];
        if (locate_cell(px, pz, base, top)) begin
            corner = '{base, base + 1, base + count_x, top};
            foreach (corner[k])
                if (!vtx_written[corner[k]]) write_vertex(int'(corner[k]), rand_height());
        end
        it.opcode = OP_QUERY;
        it.vertex_index = $urandom;
        it.vertex_height = $urandom;
        it.pos_x = px;
        it.pos_z = pz;
        send_beat(it);
    endtask

    // Drop valid and wait out every pending result plus the pipeline depth.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (heights_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[GRID_COUNT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GRID_COUNT_X: count_x = value & 32'h7fff;
            CFG_GRID_COUNT_Z: count_z = value & 32'h7fff;
            CFG_GRID_INTERVAL: interval = value & 32'h7ff;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int unsigned gx, input int unsigned gz, input int unsigned iv);
        drain_pipeline();
        write_reg(CFG_GRID_COUNT_X, gx);
        write_reg(CFG_GRID_COUNT_Z, gz);
        write_reg(CFG_GRID_INTERVAL, iv);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [POS_W-1:0] cell_pos(input longint cell_no);
        longint s;
        s = longint'(interval) << FRAC_W;
        return POS_W'(cell_no * s + longint'($urandom_range(int'(s) - 1)));
    endfunction

    task automatic test_reset_grid();
        // Reset configuration: 129 x 129 at interval 1.
        query_at(32'h0, 32'h0);
        query_at(32'h00007fff, 32'h00007fff);
        query_at(32'h00008000, 32'h0);
        query_at(32'hffffffff, 32'hffffffff);
    endtask

    task automatic test_degenerate();
        set_grid(129, 129, 0);
        query_at(32'h100, 32'h100);
        set_grid(1, 129, 1);
        query_at(32'h0, 32'h0);
        set_grid(129, 0, 1);
        query_at(32'h0, 32'h0);
    endtask

    task automatic test_extremes();
        set_grid(2, 2, 1024);
        write_vertex(0, 32'h7fffffff);
        write_vertex(1, 32'h80000000);
        write_vertex(2, 32'h80000000);
        write_vertex(3, 32'h7fffffff);
        query_at(32'h0, 32'h0);
        query_at(32'h0003ffff, 32'h0003ffff);
        query_at(32'h00020000, 32'h00020001);
        query_at(32'h00020000, 32'h00020000);
        query_at(32'h00040000, 32'h0);
        // Cells whose far vertex falls past the end of the store.
        set_grid(16384, 16384, 1);
        query_at(32'h00000100, 32'h0);
        query_at(32'h0, 32'h00000100);
        set_grid(32767, 32767, 2047);
        query_at(32'h0, 32'h0);
        query_at(32'hffffffff, 32'h0);
    endtask

    // Run until the phase has sent the given number of beats, vertex loads included.
    task automatic test_random_phase(input int unsigned gx, input int unsigned gz,
                                     input int unsigned iv, input int beats);
        int sel;
        int start_beats;
        longint cx, cz;
        set_grid(gx, gz, iv);
        start_beats = sent_beats;
        while (sent_beats - start_beats < beats) begin
            sel = $urandom_range(99);
            if (sel < 20) begin
                write_vertex($urandom_range(STORE_DEPTH - 1), rand_height());
            end else if (sel < 80) begin
                cx = $urandom_range(gx > 2 ? gx - 2 : 0);
                cz = $urandom_range(gz > 2 ? gz - 2 : 0);
                query_at(cell_pos(cx), cell_pos(cz));
            end else if (sel < 92) begin
                cx = $urandom_range(1) ? gx - 1 : $urandom_range(gx);
                cz = $urandom_range(1) ? gz - 1 : $urandom_range(gz);
                query_at(cell_pos(cx), cell_pos(cz));
            end else begin
                query_at($urandom, $urandom);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        sent_beats = 0;
        cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        count_x = 129;
        count_z = 129;
        interval = 1;
        foreach (vtx_written[i]) vtx_written[i] = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_grid();
        test_degenerate();
        test_extremes();

        test_random_phase(129, 129, 1, 250);
        src_idle_pct = 58;
        test_random_phase(2, 2, 1, 250);
        test_random_phase(120, 100, 7, 250);
        src_idle_pct = 0;
        snk_stall_pct = 58;
        test_random_phase(5, 3000, 1024, 250);
        test_random_phase(16383, 2, 3, 250);
        src_idle_pct = 38;
        snk_stall_pct = 38;
        test_random_phase(64, 256, 2047, 250);
        test_random_phase(3, 3, 1024, 250);

        drain_pipeline();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
